>>> design/multiplexed_seven_segment_counter_macros.svh
// assertion helpers shared by the counter block
`ifndef MULTIPLEXED_SEVEN_SEGMENT_COUNTER_MACROS_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_COUNTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MSC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("msc check failed");

// next-cycle implication, checked outside reset
`define MSC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("msc check failed");

`endif

>>> design/msc_pkg.sv
package msc_pkg;

    localparam int SCAN_W     = 2;
    localparam int BCD_W      = 16;
    localparam int NIBBLE_W   = 4;
    localparam int ROUNDS_W   = 16;
    localparam int SEG_W      = 7;
    localparam int EN_W       = 8;
    localparam int COUNT_W    = 14;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 16'd25;

    typedef logic [SCAN_W-1:0]   t_scan_idx;
    typedef logic [BCD_W-1:0]    t_bcd;
    typedef logic [NIBBLE_W-1:0] t_nibble;

    typedef struct packed {
        logic [COUNT_W-1:0] shown_count;
        logic [EN_W-1:0]    digit_enable;
        logic [SEG_W-1:0]   segments;
    } t_result;

endpackage

>>> design/msc_display.sv
module msc_display (
    input  msc_pkg::t_scan_idx i_scan_idx,
    input  msc_pkg::t_bcd      i_bcd,
    output msc_pkg::t_result   o_result
);
    import msc_pkg::*;

    function automatic logic [SEG_W-1:0] seg_lookup(input t_nibble d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3f;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5b;
            4'd3:    s = 7'h4f;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6d;
            4'd6:    s = 7'h7d;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7f;
            4'd9:    s = 7'h6f;
            default: s = '0;
        endcase
        return s;
    endfunction

    t_nibble w_digit;
    t_nibble w_d0, w_d1, w_d2, w_d3;

    assign w_d0    = i_bcd[3:0];
    assign w_d1    = i_bcd[7:4];
    assign w_d2    = i_bcd[11:8];
    assign w_d3    = i_bcd[15:12];
    assign w_digit = i_bcd[{i_scan_idx, 2'b00} +: NIBBLE_W];

    always_comb begin
        o_result.segments     = seg_lookup(w_digit);
        // odd counts move the enable to the upper bank
        o_result.digit_enable = EN_W'(1) << {w_d0[0], i_scan_idx};
        o_result.shown_count  = COUNT_W'(w_d0)
                              + COUNT_W'(w_d1) * COUNT_W'(10)
                              + COUNT_W'(w_d2) * COUNT_W'(100)
                              + COUNT_W'(w_d3) * COUNT_W'(1000);
    end

endmodule

>>> design/multiplexed_seven_segment_counter.sv
// an accepted input's result is registered into the output entry, or into
// the skid entry if the output stalls; throughput: one item per cycle while
// the skid is empty; the two-entry buffer keeps input ready while one result waits
// reset (synchronous, active low): count, scan index and round counter go to
// zero, rounds_per_count goes to 25, both output entries are emptied
module multiplexed_seven_segment_counter #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [msc_pkg::ROUNDS_W-1:0]     i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [msc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [0] advance
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [6:0] segments, [14:7] digit_enable, [28:15] shown_count
    output logic [msc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import msc_pkg::*;

    `include "multiplexed_seven_segment_counter_macros.svh"

    function automatic t_bcd bcd_inc(input t_bcd v);
        t_bcd    r;
        logic    carry;
        t_nibble d;
        r     = '0;
        carry = 1'b1;
        for (int i = 0; i < 4; i++) begin
            d = v[i*NIBBLE_W +: NIBBLE_W];
            if (carry) begin
                if (d >= 4'd9) begin
                    d = '0;
                end else begin
                    d     = d + 4'd1;
                    carry = 1'b0;
                end
            end
            r[i*NIBBLE_W +: NIBBLE_W] = d;
        end
        return r;
    endfunction

    logic [ROUNDS_W-1:0] r_rounds;
    t_scan_idx           r_scan_idx, n_scan_idx;
    logic [ROUNDS_W-1:0] r_round_cnt, n_round_cnt;
    t_bcd                r_bcd, n_bcd;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    t_result w_result;

    logic w_in_acc, w_out_acc;
    logic [SCAN_W:0]   w_next_idx;
    logic [ROUNDS_W:0] w_round_inc;

    msc_display u_display (
        .i_scan_idx (r_scan_idx),
        .i_bcd      (r_bcd),
        .o_result   (w_result)
    );

    assign s_axis_tready = !r_skid_valid;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_out};

    assign w_next_idx  = {1'b0, r_scan_idx} + (SCAN_W+1)'(1);
    assign w_round_inc = {1'b0, r_round_cnt} + (ROUNDS_W+1)'(1);

    always_comb begin
        n_scan_idx  = r_scan_idx;
        n_round_cnt = r_round_cnt;
        n_bcd       = r_bcd;
        if (w_in_acc && s_axis_tdata[0]) begin
            if (w_next_idx >= (SCAN_W+1)'(NUM_DIGITS)) begin
                n_scan_idx = '0;
                // a zero register behaves as one round
                if (w_round_inc >= {1'b0, r_rounds}) begin
                    n_round_cnt = '0;
                    n_bcd       = bcd_inc(r_bcd);
                end else begin
                    n_round_cnt = w_round_inc[ROUNDS_W-1:0];
                end
            end else begin
                n_scan_idx = w_next_idx[SCAN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rounds    <= ROUNDS_RESET;
            r_scan_idx  <= '0;
            r_round_cnt <= '0;
            r_bcd       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rounds <= i_cfg_wdata;
            end
            r_scan_idx  <= n_scan_idx;
            r_round_cnt <= n_round_cnt;
            r_bcd       <= n_bcd;
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_out_acc) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_in_acc;
                end
            end else if (w_in_acc) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_acc) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end
        if (w_in_acc && r_out_valid && !w_out_acc) begin
            r_skid <= w_result;
        end
    end

    `MSC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    `MSC_ASSERT_NOW(a_scan_in_range, 1'b1, {1'b0, r_scan_idx} < (SCAN_W+1)'(NUM_DIGITS))
    `MSC_ASSERT_NOW(a_bcd_valid, 1'b1,
        r_bcd[3:0] <= 4'd9 && r_bcd[7:4] <= 4'd9 && r_bcd[11:8] <= 4'd9 && r_bcd[15:12] <= 4'd9)
    `MSC_ASSERT_NEXT(a_stall_fills_skid, w_in_acc && r_out_valid && !m_axis_tready, r_skid_valid)
    `MSC_ASSERT_NEXT(a_hold_without_advance, w_in_acc && !s_axis_tdata[0] && !i_cfg_we,
        $stable(r_bcd) && $stable(r_scan_idx) && $stable(r_round_cnt))

endmodule

>>> verif/tb_multiplexed_seven_segment_counter.sv
`timescale 1ns / 1ps

module tb_multiplexed_seven_segment_counter;
    import msc_pkg::*;

    localparam int NUM_DIGITS     = 4;
    localparam int CYCLE_LIMIT    = 100_000;
    localparam int LONG_HOLD      = 60;
    localparam int ZERO_RUN_TICKS = 4 * 10;
    localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = 16'hffff;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [ROUNDS_W-1:0]    i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [0] advance
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [6:0] segments, [14:7] digit_enable, [28:15] shown_count
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    multiplexed_seven_segment_counter #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // advance flags waiting to be sent, and display results still owed
    logic    tick_queue[$];
    t_result expected_display[$];

    logic quiet = 1'b0;
    logic stall_kick = 1'b0;
    logic kick_seen = 1'b0;
    int   hold_left = 0;
    int   send_gap = 0;
    int   recv_wait = 0;
    int   error_count = 0;
    int   cycle_count = 0;

    // display state as the block should hold it
    t_scan_idx           disp_scan;
    logic [ROUNDS_W-1:0] disp_rounds_done;
    t_bcd                disp_bcd;
    logic [ROUNDS_W-1:0] disp_rounds_cfg;

    function automatic logic [SEG_W-1:0] seg_pattern(input t_nibble digit);
        case (digit)
            4'd0:    return 7'h3f;
            4'd1:    return 7'h06;
            4'd2:    return 7'h5b;
            4'd3:    return 7'h4f;
            4'd4:    return 7'h66;
            4'd5:    return 7'h6d;
            4'd6:    return 7'h7d;
            4'd7:    return 7'h07;
            4'd8:    return 7'h7f;
            4'd9:    return 7'h6f;
            default: return 7'h00;
        endcase
    endfunction

    function automatic t_bcd bcd_next(input t_bcd v);
        t_bcd    r;
        logic    carry;
        t_nibble d;
        r = '0;
        carry = 1'b1;
        for (int i = 0; i < 4; i++) begin
            d = v[i*4 +: 4];
            if (carry) begin
                if (d >= 4'd9) begin
                    d = 4'd0;
                end else begin
                    d = d + 4'd1;
                    carry = 1'b0;
                end
            end
            r[i*4 +: 4] = d;
        end
        return r;
    endfunction

    // output is formed from the current state, then the state steps on advance
    task automatic display_tick(input logic advance, output t_result r);
        t_nibble digit;
        int      count_val;
        digit = disp_bcd[{disp_scan, 2'b00} +: 4];
        count_val = disp_bcd[3:0] + 10 * disp_bcd[7:4] + 100 * disp_bcd[11:8]
                  + 1000 * disp_bcd[15:12];
        r.segments     = seg_pattern(digit);
        r.digit_enable = EN_W'(1) << (int'(disp_scan) + (disp_bcd[0] ? 4 : 0));
        r.shown_count  = COUNT_W'(count_val);
        if (advance) begin
            if (int'(disp_scan) + 1 >= NUM_DIGITS) begin
                disp_scan = '0;
                // a zero register behaves like one
                if (int'(disp_rounds_done) + 1 >= int'(disp_rounds_cfg)) begin
                    disp_rounds_done = '0;
                    disp_bcd = bcd_next(disp_bcd);
                end else begin
                    disp_rounds_done = disp_rounds_done + 1'b1;
                end
            end else begin
                disp_scan = disp_scan + 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (tick_queue.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= IN_TDATA_W'(tick_queue.pop_front());
                send_gap <= quiet ? 0 : $urandom_range(0, 3);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, started by a toggle of stall_kick
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            kick_seen <= 1'b0;
        end else if (stall_kick != kick_seen) begin
            kick_seen <= stall_kick;
            hold_left <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver
    always @(posedge i_clk) begin : receiver
        int w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait <= 0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            m_axis_tready <= (recv_wait == 1);
        end else if (m_axis_tready && m_axis_tvalid) begin
            w = quiet ? 0 : $urandom_range(0, 3);
            recv_wait <= w;
            m_axis_tready <= (w == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: predicts on the input side, checks on the output side
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            disp_scan = '0;
            disp_rounds_done = '0;
            disp_bcd = '0;
            disp_rounds_cfg = ROUNDS_RESET;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                display_tick(s_axis_tdata[0], want);
                expected_display.push_back(want);
            end
            if (i_cfg_we)
                disp_rounds_cfg = i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[COUNT_W+EN_W+SEG_W-1:0]);
                if (expected_display.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected item on output: 0x%0h", m_axis_tdata);
                end else begin
                    want = expected_display.pop_front();
                    if (got.segments !== want.segments)
                        report_mismatch("segments", want.segments, got.segments);
                    if (got.digit_enable !== want.digit_enable)
                        report_mismatch("digit_enable", want.digit_enable,
                                        got.digit_enable);
                    if (got.shown_count !== want.shown_count)
                        report_mismatch("shown_count", want.shown_count, got.shown_count);
                    if (m_axis_tdata[OUT_TDATA_W-1:COUNT_W+EN_W+SEG_W] !== '0)
                        report_mismatch("padding", 0,
                                        m_axis_tdata[OUT_TDATA_W-1:COUNT_W+EN_W+SEG_W]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_multiplexed_seven_segment_counter: errors");
            $finish;
        end
    end

    task automatic push_ticks(input int n, input int pct_advance);
        @(negedge i_clk);
        for (int i = 0; i < n; i++)
            tick_queue.push_back($urandom_range(1, 100) <= pct_advance);
    endtask

    task automatic push_tick(input logic advance);
        @(negedge i_clk);
        tick_queue.push_back(advance);
    endtask

    // wait until every item is sent and every result is back
    task automatic settle();
        while (tick_queue.size() != 0 || s_axis_tvalid || expected_display.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_rounds(input logic [ROUNDS_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int ones;
        int pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hold ticks and one full scan at the reset rounds value
        push_tick(1'b0);
        push_tick(1'b0);
        for (int i = 0; i < 4; i++)
            push_tick(1'b1);
        settle();

        // one round per count: units step 0..3, odd counts use the upper bank
        write_rounds(16'd1);
        for (int i = 0; i < 12; i++)
            push_tick(1'b1);
        push_tick(1'b0);
        settle();

        // largest register value, then lowered below the rounds already done
        write_rounds(ROUNDS_MAX);
        for (int i = 0; i < 8; i++)
            push_tick(1'b1);
        settle();
        write_rounds(16'd1);
        for (int i = 0; i < 4; i++)
            push_tick(1'b1);
        settle();

        // zero register acts as one round, units carry into tens
        write_rounds(16'd0);
        ones = 0;
        @(negedge i_clk);
        while (ones < ZERO_RUN_TICKS) begin
            if ($urandom_range(0, 15) == 0) begin
                tick_queue.push_back(1'b0);
            end else begin
                tick_queue.push_back(1'b1);
                ones++;
            end
        end
        settle();

        // random phases, each with its own rounds setting
        for (int phase = 0; phase < 13; phase++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_rounds(16'd0);
            else if (pick == 1)
                write_rounds(ROUNDS_MAX);
            else if (pick == 2)
                write_rounds(ROUNDS_W'($urandom_range(5, 40)));
            else
                write_rounds(ROUNDS_W'($urandom_range(1, 4)));
            quiet <= (phase == 3);
            push_ticks(100, 85);
            if (phase == 6) begin
                // receiver holds off while items keep coming
                @(posedge i_clk);
                stall_kick <= ~stall_kick;
            end
            settle();
        end
        quiet <= 1'b0;

        settle();
        repeat (5) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_multiplexed_seven_segment_counter: clean");
        else
            $display("tb_multiplexed_seven_segment_counter: errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/msc_pkg.sv
design/msc_display.sv
design/multiplexed_seven_segment_counter.sv
verif/tb_multiplexed_seven_segment_counter.sv
